@@ rtl/twc_pkg.sv @@
// Shared types and constants for the trailing whitespace chomp block.
// Holds the sequencer state type and the byte class helpers.
// No dependencies.
package twc_pkg;

  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_TAB   = 8'h09;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SEND,
    ST_EOS_TEST0,
    ST_EOS_TEST1
  } state_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CODE_SPACE) || ((b >= CODE_TAB) && (b <= CODE_CR));
  endfunction

endpackage

@@ rtl/twc_ram.sv @@
// Pending byte store: one write port and one registered read port.
// Used by twc_seq through the top level; no package dependencies.
module twc_ram #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/twc_seq.sv @@
// Sequencer for the trailing whitespace chomp block: request intake, held run
// count, drain and end-of-stream checks, and the output register.
// Depends on twc_pkg; drives the store in twc_ram.
module twc_seq import twc_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             last_of_run,
  output logic                             overflow_seen,
  output logic                             mem_we,
  output logic [$clog2(PENDING_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                       mem_wdata,
  output logic [$clog2(PENDING_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                       mem_rdata
);

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   idx_inc;
  logic [7:0]      hold_byte;
  logic            first;
  logic            dropped;
  logic            accept;
  logic            byte_ws;
  logic            full;
  logic            load;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;

  assign accept  = in_valid && (state == ST_IDLE);
  assign byte_ws = is_ws(in_byte);
  assign full    = (count == CW'(PENDING_DEPTH));
  assign load    = !out_valid || !out_stall;
  assign idx_inc = idx + CW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_EOS) begin
            state_next = (count != '0) ? ST_EOS_TEST0 : ST_IDLE;
          end else if (!byte_ws) begin
            state_next = (count != '0) ? ST_DRAIN : ST_SEND;
          end
        end
      end
      ST_DRAIN: begin
        if (load && (idx_inc == count)) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      ST_EOS_TEST0: begin
        if (mem_rdata == CODE_LF) begin
          state_next = ST_SEND;
        end else if ((mem_rdata == CODE_CR) && (count > CW'(1))) begin
          state_next = ST_EOS_TEST1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EOS_TEST1: begin
        if (mem_rdata != CODE_LF) begin
          state_next = ST_IDLE;
        end else if (load) begin
          state_next = ST_SEND;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = accept && (command == CMD_DATA) && byte_ws && !full;
    mem_waddr = count[AW-1:0];
    mem_wdata = in_byte;
    mem_raddr = idx[AW-1:0];
    emit      = 1'b0;
    emit_byte = hold_byte;
    emit_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_DRAIN: begin
        if (load) begin
          emit      = 1'b1;
          emit_byte = mem_rdata;
          mem_raddr = idx_inc[AW-1:0];
        end
      end
      ST_SEND: begin
        emit      = load;
        emit_last = 1'b1;
      end
      ST_EOS_TEST0: begin
        mem_raddr = AW'(1);
      end
      ST_EOS_TEST1: begin
        mem_raddr = AW'(1);
        if (load && (mem_rdata == CODE_LF)) begin
          emit      = 1'b1;
          emit_byte = CODE_CR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      first     <= 1'b0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        count <= count + CW'(1);
      end
      if (accept && (command == CMD_DATA) && byte_ws && full) begin
        dropped <= 1'b1;
      end
      if (accept) begin
        first <= 1'b1;
        idx   <= '0;
      end
      if ((state == ST_DRAIN) && emit) begin
        idx <= idx_inc;
      end
      if ((state != ST_IDLE) && (state_next == ST_IDLE)) begin
        count <= '0;
        idx   <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        first     <= 1'b0;
        if (first) begin
          dropped <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= in_byte;
    end else if ((state == ST_EOS_TEST0) || (state == ST_EOS_TEST1)) begin
      hold_byte <= CODE_LF;
    end
    if (emit) begin
      out_byte      <= emit_byte;
      last_of_run   <= emit_last;
      overflow_seen <= first && dropped;
    end
  end

endmodule

@@ rtl/trailing_whitespace_chomp.sv @@
// Trailing whitespace chomp: holds whitespace runs and releases them only
// when a non-whitespace byte follows; an LF or CR LF at the head of a run survives end of stream.
// Depends on twc_pkg, twc_ram and twc_seq.
//
// Usage:
//   Input requests carry command and in_byte and are taken when in_valid is
//   high and in_stall is low. Output requests carry out_byte, last_of_run and
//   overflow_seen and are taken when out_valid is high and out_stall is low.
//   A whitespace byte is stored in the pending RAM and gives no output; when
//   the RAM is full it is dropped and sets the drop flag. A non-whitespace
//   byte with N bytes held gives N + 1 outputs, one per cycle while the
//   receiver does not stall; the drain loop reads one RAM entry per cycle
//   while the output is not stalled. An end-of-stream request reads the
//   first one or two held entries and gives at most two outputs, or gives
//   no output when nothing is held. The first output of a request is
//   registered and is not given while the request is being taken.
//   in_stall is high while a request is in work; a stalled output holds the
//   sequencer in any state that would give an output, and the RAM read
//   address is kept steady. Reset clears the held count, the drop flag and
//   the output valid flag; the RAM is not cleared and needs no clearing pass.
module trailing_whitespace_chomp import twc_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       overflow_seen
);

  localparam int AW = $clog2(PENDING_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  twc_ram #(
    .DEPTH(PENDING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  twc_seq #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .overflow_seen(overflow_seen),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // A result that is not the last of its request means the request is still in work.
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> in_stall)
    else $error("input ready while a run is incomplete");

  // The drop flag is reported only on the first result of a request.
  a_ovf_first_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=> !(out_valid && overflow_seen))
    else $error("overflow flag on a later result of a request");

  // A new request is never taken while a non-final result waits.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(out_valid && !last_of_run))
    else $error("request accepted during an incomplete run");

endmodule
